[design/quadrature_decoder_speed_defines.svh]
// assertion macros for the quadrature decoder with speed measurement
// used by qds_div and quadrature_decoder_speed; no other dependencies
`ifndef QUADRATURE_DECODER_SPEED_DEFINES_SVH
`define QUADRATURE_DECODER_SPEED_DEFINES_SVH

`ifndef NO_ASSERTIONS
// property must hold at every clock edge outside reset
`define QDS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("%m: assertion failed");
// expression must never be true outside reset
`define QDS_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
    else $error("%m: forbidden condition seen");
`else
`define QDS_ASSERT(lbl, clk, rstn, prop)
`define QDS_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

[design/qds_pkg.sv]
// shared types, constants and gray-code tables for the quadrature decoder
// no dependencies
package qds_pkg;

  // fixed field widths
  localparam int DPP_BITS      = 24;
  localparam int PRESET_BITS   = 24;
  localparam int TOTAL_BITS    = 24;
  localparam int ANGLE_BITS    = 48;
  localparam int SPEED_BITS    = 41;
  localparam int DPP_SHIFT     = 16;
  localparam int QUOT_BITS     = DPP_BITS + DPP_SHIFT;
  localparam int STEP_BITS     = 2;
  localparam int STEPS_PER_PULSE = 4;
  localparam int TDATA_IN_BITS = 8;
  localparam int TUSER_IN_BITS = 2;
  localparam int TDATA_OUT_BITS = 120;
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;

  localparam logic [DPP_BITS-1:0]    DPP_RESET    = 24'd65536;
  localparam logic [PRESET_BITS-1:0] PRESET_RESET = 24'd0;

  // register index codes (taken from paddr bit 2)
  localparam logic REG_DPP    = 1'b0;
  localparam logic REG_PRESET = 1'b1;

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_CLEAR  = 2'd1,
    MODE_PRESET = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    HEAD_STILL = 2'd0,
    HEAD_CW    = 2'd1,
    HEAD_CCW   = 2'd2
  } heading_e;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_STEP = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_MUL  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_e;

  // step outcome from the tracker to the sequencer
  typedef struct packed {
    logic     pulse;
    heading_e dir;
    heading_e heading;
  } trk_t;

  // next code going clockwise: 00-10-11-01-00
  function automatic logic [1:0] cw_next(input logic [1:0] code);
    logic [1:0] nxt;
    case (code)
      2'b00:   nxt = 2'b10;
      2'b01:   nxt = 2'b00;
      2'b10:   nxt = 2'b11;
      2'b11:   nxt = 2'b01;
      default: nxt = 2'b00;
    endcase
    return nxt;
  endfunction

  // next code going anticlockwise
  function automatic logic [1:0] ccw_next(input logic [1:0] code);
    logic [1:0] nxt;
    case (code)
      2'b00:   nxt = 2'b01;
      2'b01:   nxt = 2'b11;
      2'b10:   nxt = 2'b00;
      2'b11:   nxt = 2'b10;
      default: nxt = 2'b00;
    endcase
    return nxt;
  endfunction

endpackage

[design/qds_div.sv]
// restoring radix-2 divider, one quotient bit per cycle
// depends on qds_pkg and quadrature_decoder_speed_defines.svh
`include "quadrature_decoder_speed_defines.svh"

module qds_div #(
  parameter int DEN_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [qds_pkg::QUOT_BITS-1:0] dividend_i,
  input  logic [DEN_BITS-1:0]          divisor_i,
  output logic                         done_o,
  output logic [qds_pkg::QUOT_BITS-1:0] quot_o
);

  localparam int QB    = qds_pkg::QUOT_BITS;
  localparam int CNT_W = $clog2(QB);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [QB-1:0]       acc_q;
  logic [DEN_BITS-1:0] rem_q;
  logic [DEN_BITS-1:0] den_q;
  logic [DEN_BITS+1:0] trial;
  logic                fits;
  logic                last_step;

  // trial subtract of the shifted remainder
  assign trial = {1'b0, rem_q, acc_q[QB-1]} - {2'b00, den_q};
  assign fits  = ~trial[DEN_BITS+1];
  assign last_step = busy_q && (cnt_q == CNT_W'(QB - 1));

  // control
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + CNT_W'(1);
      if (last_step) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath: dividend shifts out the top while quotient bits shift in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      acc_q <= {acc_q[QB-2:0], fits};
      if (fits) begin
        rem_q <= trial[DEN_BITS-1:0];
      end else begin
        rem_q <= {rem_q[DEN_BITS-2:0], acc_q[QB-1]};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = acc_q;

  // checks
  `QDS_ASSERT_NEVER(a_start_busy, clk_i, rst_ni, start_i && busy_q)
  `QDS_ASSERT(a_done_after_busy, clk_i, rst_ni, done_q |-> $past(busy_q) && !busy_q)
  `QDS_ASSERT(a_last_ends, clk_i, rst_ni, last_step && !start_i |=> done_q)

endmodule

[design/qds_track.sv]
// gray-code step tracker: position, heading, step and tick counters
// depends on qds_pkg
module qds_track #(
  parameter int COUNT_BITS = 24,
  parameter int TIMER_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  qds_pkg::mode_e                    mode_i,
  input  logic [1:0]                        code_i,
  input  logic [qds_pkg::PRESET_BITS-1:0]   preset_i,
  output qds_pkg::trk_t                     trk_o,
  output logic [TIMER_BITS-1:0]             divisor_o,
  output logic [COUNT_BITS-1:0]             count_o
);

  logic [1:0]                 last_q, last_d;
  logic                       primed_q, primed_d;
  qds_pkg::heading_e          heading_q, heading_d;
  logic [qds_pkg::STEP_BITS-1:0] step_q, step_d;
  logic [COUNT_BITS-1:0]      count_q, count_d;
  logic [TIMER_BITS-1:0]      ticks_q, ticks_d;

  logic [TIMER_BITS-1:0]      ticks_inc;
  logic [qds_pkg::STEP_BITS:0] sc;
  qds_pkg::heading_e          dir;
  logic                       pulse;
  logic signed [63:0]         preset_ext;

  assign ticks_inc  = (&ticks_q) ? ticks_q : ticks_q + TIMER_BITS'(1);
  assign preset_ext = 64'(signed'(preset_i));
  // timer value seen by the pulse that this step may complete
  assign divisor_o  = (heading_q == qds_pkg::HEAD_STILL) ? TIMER_BITS'(1) : ticks_inc;

  // next state for the current command
  always_comb begin
    last_d    = last_q;
    primed_d  = primed_q;
    heading_d = heading_q;
    step_d    = step_q;
    count_d   = count_q;
    ticks_d   = ticks_q;
    dir       = qds_pkg::HEAD_STILL;
    pulse     = 1'b0;
    sc        = {1'b0, step_q};
    case (mode_i)
      qds_pkg::MODE_TICK: begin
        ticks_d = ticks_inc;
        if (!primed_q) begin
          primed_d = 1'b1;
          last_d   = code_i;
        end else if (code_i == qds_pkg::cw_next(last_q)) begin
          dir = qds_pkg::HEAD_CW;
        end else if (code_i == qds_pkg::ccw_next(last_q)) begin
          dir = qds_pkg::HEAD_CCW;
        end
        if (dir != qds_pkg::HEAD_STILL) begin
          last_d = code_i;
          // start from still or reversal restarts the step count
          if (heading_q == qds_pkg::HEAD_STILL) begin
            ticks_d = TIMER_BITS'(1);
            sc      = '0;
          end else if (heading_q != dir) begin
            sc = '0;
          end
          heading_d = dir;
          sc        = sc + 3'd1;
          if (sc >= 3'(qds_pkg::STEPS_PER_PULSE)) begin
            pulse   = 1'b1;
            step_d  = '0;
            ticks_d = '0;
            if (dir == qds_pkg::HEAD_CW) begin
              count_d = count_q + COUNT_BITS'(1);
            end else begin
              count_d = count_q - COUNT_BITS'(1);
            end
          end else begin
            step_d = sc[qds_pkg::STEP_BITS-1:0];
          end
        end
      end
      qds_pkg::MODE_CLEAR: begin
        count_d   = '0;
        heading_d = qds_pkg::HEAD_STILL;
      end
      qds_pkg::MODE_PRESET: begin
        count_d   = preset_ext[COUNT_BITS-1:0];
        heading_d = qds_pkg::HEAD_STILL;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q    <= '0;
      primed_q  <= 1'b0;
      heading_q <= qds_pkg::HEAD_STILL;
      step_q    <= '0;
      count_q   <= '0;
      ticks_q   <= '0;
    end else if (en_i) begin
      last_q    <= last_d;
      primed_q  <= primed_d;
      heading_q <= heading_d;
      step_q    <= step_d;
      count_q   <= count_d;
      ticks_q   <= ticks_d;
    end
  end

  assign trk_o.pulse   = pulse;
  assign trk_o.dir     = dir;
  assign trk_o.heading = heading_q;
  assign count_o       = count_q;

endmodule

[design/quadrature_decoder_speed.sv]
// Quadrature decoder with pulse count, angle and speed.
// Input stream: one command per transaction; tuser carries the mode (sample tick,
// clear position, preset position), tdata carries the A and B levels.
// Output stream: one result per input transaction with pulse count, angle, speed,
// rotation and a flag that this sample completed a counted pulse.
// APB port: register 0 degrees_per_pulse at 0x0, register 1 preset_count at 0x4;
// write only while the block is idle.
// Sequence: a command without a counted pulse passes from the step state through the
// multiply state into the output register, and the next command waits for delivery.
// A counted pulse also runs the divider for speed between those two states, one
// quotient bit per cycle over 40 bits.
// Only one command is in flight: s_axis_tready is high while the sequencer is idle.
// A result waits in the output register while the receiver stalls, and no new
// command is taken until it is delivered.
// Reset clears position, heading, counters and speed and restores the register
// defaults; the first sample after reset only primes the decoder.
// depends on qds_pkg, qds_track, qds_div, quadrature_decoder_speed_defines.svh
`include "quadrature_decoder_speed_defines.svh"

module quadrature_decoder_speed #(
  parameter int COUNT_BITS = 24,
  parameter int TIMER_BITS = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input stream
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [qds_pkg::TDATA_IN_BITS-1:0]    s_axis_tdata_i,  // chan_a, chan_b
  input  logic [qds_pkg::TUSER_IN_BITS-1:0]    s_axis_tuser_i,  // mode
  // output stream
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // pulse_total, angle_value, speed_value, rotation, pulse_seen
  output logic [qds_pkg::TDATA_OUT_BITS-1:0]   m_axis_tdata_o,
  // configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [qds_pkg::APB_ADDR_BITS-1:0]    paddr,
  input  logic [qds_pkg::APB_DATA_BITS-1:0]    pwdata,
  output logic [qds_pkg::APB_DATA_BITS-1:0]    prdata,
  output logic                                 pready
);

  localparam int PROD_W = COUNT_BITS + qds_pkg::DPP_BITS + 1;

  qds_pkg::state_e state_q, state_d;
  qds_pkg::mode_e  mode_q;
  logic [1:0]      code_q;
  logic            pulse_q;
  qds_pkg::heading_e dir_q;

  logic [qds_pkg::DPP_BITS-1:0]    dpp_q;
  logic [qds_pkg::PRESET_BITS-1:0] preset_q;
  logic [qds_pkg::SPEED_BITS-1:0]  speed_q;
  logic [qds_pkg::TDATA_OUT_BITS-1:0] tdata_q;

  logic                         s_hs;
  logic                         m_hs;
  logic                         cfg_wr;
  logic                         trk_en;
  logic                         div_start;
  logic                         div_done;
  logic [qds_pkg::QUOT_BITS-1:0] quot;
  logic [qds_pkg::SPEED_BITS-1:0] quot_ext;
  qds_pkg::trk_t                trk;
  logic [TIMER_BITS-1:0]        divisor;
  logic [COUNT_BITS-1:0]        count;
  logic signed [PROD_W-1:0]     product;
  logic signed [63:0]           product_ext;
  logic signed [63:0]           count_ext;

  assign s_hs   = s_axis_tvalid_i && s_axis_tready_o;
  assign m_hs   = m_axis_tvalid_o && m_axis_tready_i;
  assign cfg_wr = psel && penable && pwrite && pready;

  assign s_axis_tready_o = (state_q == qds_pkg::ST_IDLE);
  assign m_axis_tvalid_o = (state_q == qds_pkg::ST_OUT);
  assign m_axis_tdata_o  = tdata_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dpp_q    <= qds_pkg::DPP_RESET;
      preset_q <= qds_pkg::PRESET_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == qds_pkg::REG_DPP) begin
        dpp_q <= pwdata[qds_pkg::DPP_BITS-1:0];
      end else begin
        preset_q <= pwdata[qds_pkg::PRESET_BITS-1:0];
      end
    end
  end

  // register readback
  always_comb begin
    if (paddr[2] == qds_pkg::REG_PRESET) begin
      prdata = qds_pkg::APB_DATA_BITS'(preset_q);
    end else begin
      prdata = qds_pkg::APB_DATA_BITS'(dpp_q);
    end
  end
  assign pready = 1'b1;

  // sequencer
  always_comb begin
    state_d   = state_q;
    trk_en    = 1'b0;
    div_start = 1'b0;
    case (state_q)
      qds_pkg::ST_IDLE: begin
        if (s_hs) state_d = qds_pkg::ST_STEP;
      end
      qds_pkg::ST_STEP: begin
        trk_en = 1'b1;
        if (trk.pulse) begin
          div_start = 1'b1;
          state_d   = qds_pkg::ST_DIV;
        end else begin
          state_d = qds_pkg::ST_MUL;
        end
      end
      qds_pkg::ST_DIV: begin
        if (div_done) state_d = qds_pkg::ST_MUL;
      end
      qds_pkg::ST_MUL: begin
        state_d = qds_pkg::ST_OUT;
      end
      qds_pkg::ST_OUT: begin
        if (m_hs) state_d = qds_pkg::ST_IDLE;
      end
      default: begin
        state_d = qds_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= qds_pkg::ST_IDLE;
      pulse_q <= 1'b0;
      dir_q   <= qds_pkg::HEAD_STILL;
      speed_q <= '0;
    end else begin
      state_q <= state_d;
      if (trk_en) begin
        pulse_q <= trk.pulse;
        dir_q   <= trk.dir;
      end
      // latch signed speed when the divider finishes
      if (state_q == qds_pkg::ST_DIV && div_done) begin
        if (dir_q == qds_pkg::HEAD_CW) begin
          speed_q <= quot_ext;
        end else begin
          speed_q <= '0 - quot_ext;
        end
      end
    end
  end

  // accepted command
  always_ff @(posedge clk_i) begin
    if (s_hs) begin
      mode_q <= qds_pkg::mode_e'(s_axis_tuser_i);
      code_q <= {s_axis_tdata_i[0], s_axis_tdata_i[1]};
    end
  end

  assign quot_ext = qds_pkg::SPEED_BITS'(quot);

  qds_track #(
    .COUNT_BITS (COUNT_BITS),
    .TIMER_BITS (TIMER_BITS)
  ) u_track (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (trk_en),
    .mode_i    (mode_q),
    .code_i    (code_q),
    .preset_i  (preset_q),
    .trk_o     (trk),
    .divisor_o (divisor),
    .count_o   (count)
  );

  qds_div #(
    .DEN_BITS (TIMER_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({dpp_q, qds_pkg::DPP_SHIFT'(0)}),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // angle multiply and result register
  assign product     = PROD_W'(signed'(count)) * PROD_W'(signed'({1'b0, dpp_q}));
  assign product_ext = 64'(product);
  assign count_ext   = 64'(signed'(count));

  always_ff @(posedge clk_i) begin
    if (state_q == qds_pkg::ST_MUL) begin
      tdata_q <= {4'b0000, pulse_q, trk.heading, speed_q,
                  product_ext[qds_pkg::ANGLE_BITS-1:0],
                  count_ext[qds_pkg::TOTAL_BITS-1:0]};
    end
  end

  // checks
  `QDS_ASSERT(a_state_onehot, clk_i, rst_ni, $onehot(state_q))
  `QDS_ASSERT(a_done_in_div, clk_i, rst_ni, div_done |-> state_q == qds_pkg::ST_DIV)
  `QDS_ASSERT(a_speed_held, clk_i, rst_ni,
    (state_q == qds_pkg::ST_MUL && !pulse_q) |-> $stable(speed_q))
  `QDS_ASSERT_NEVER(a_busy_take, clk_i, rst_ni, s_axis_tready_o && m_axis_tvalid_o)

endmodule
